[hw/rtl/ultimate_oscillator_assert.svh]
// ----------------------------------------------------------------------------
// Ultimate oscillator assertion macros
// Same-cycle and next-cycle implication checks on clock, reset held off.
// ----------------------------------------------------------------------------
`ifndef ULTIMATE_OSCILLATOR_ASSERT_SVH
`define ULTIMATE_OSCILLATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define UO_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ultimate_oscillator check failed");

// antecedent implies consequent in the next cycle
`define UO_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ultimate_oscillator check failed");

`endif

[hw/rtl/ultosc_pkg.sv]
// ----------------------------------------------------------------------------
// Ultimate oscillator package
// Shared types, codes and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none
package ultosc_pkg;

   localparam int WIN_W       = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int FRAC_BITS   = 16;
   localparam int Q_W         = 19;
   localparam int TOTAL_W     = 19;
   localparam int SCALED_W    = 26;
   localparam int OSC_W       = 23;
   localparam int STATUS_W    = 2;
   localparam int CNT_W       = 5;
   localparam int SCALE       = 100;
   localparam int RECIP_SHIFT = 29;
   localparam int RECIP_W     = 27;
   localparam longint RECIP_MUL = ((64'd1 << RECIP_SHIFT) + 6) / 7;
   localparam int PROD_W      = SCALED_W + RECIP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIUM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NONE = 2'd3;

   localparam logic [WIN_W-1:0] SHORT_RST  = 9'd7;
   localparam logic [WIN_W-1:0] MEDIUM_RST = 9'd14;
   localparam logic [WIN_W-1:0] LONG_RST   = 9'd28;

   localparam logic [OSC_W-1:0] OSC_MAX = 23'd6553600;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_RD,
      S_SUB,
      S_ADD,
      S_DIV_LOAD,
      S_DIV_PRE,
      S_DIV_STEP,
      S_MUL,
      S_RECIP,
      S_OUT
   } state_type;

endpackage
`default_nettype wire

[hw/rtl/ultosc_ram.sv]
// ----------------------------------------------------------------------------
// Ultimate oscillator RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ultosc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

[hw/rtl/ultimate_oscillator.sv]
// Flow: an accepted bar passes through window reads, sums, three serial divides
// on the shared divider and scaling before its result beat; a bad window
// configuration goes straight to S_OUT with no divide; the first bar of a
// series, and every bar until the long window has filled, gives none.
// A new bar is taken only in S_IDLE; a stalled result beat holds S_OUT.
// Reset: synchronous, active high; windows 7/14/28, series cleared, ring kept.
// ----------------------------------------------------------------------------
// Ultimate oscillator
// Sliding-window buying pressure / true range ratios with a serial divider.
// ----------------------------------------------------------------------------
`default_nettype none
module ultimate_oscillator #(
   parameter int MAX_WINDOW = 256,
   parameter int PRICE_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [PRICE_BITS-1:0]              req_high_price,
   input  wire logic [PRICE_BITS-1:0]              req_low_price,
   input  wire logic [PRICE_BITS-1:0]              req_close_price,
   input  wire logic                               req_restart,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [ultosc_pkg::OSC_W-1:0]            rsp_oscillator,
   output logic [ultosc_pkg::STATUS_W-1:0]         rsp_status,
   input  wire logic                               csr_we,
   input  wire logic [ultosc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ultosc_pkg::WIN_W-1:0]       csr_wdata
);
   localparam int WIN_W = ultosc_pkg::WIN_W;
   localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int IW    = ((AW > WIN_W) ? AW : WIN_W) + 2;
   localparam int BW    = $clog2(MAX_WINDOW + 2);
   localparam int SUM_W = PRICE_BITS + $clog2(MAX_WINDOW + 1);
   localparam int REM_W = SUM_W + 1;
   localparam int Q_W   = ultosc_pkg::Q_W;
   localparam int CNT_W = ultosc_pkg::CNT_W;

   ultosc_pkg::state_type state_ff, state_in;

   logic [WIN_W-1:0]      win_ff [3];
   logic [WIN_W-1:0]      win_in [3];
   logic [PRICE_BITS-1:0] hi_ff, hi_in, lo_ff, lo_in, cl_ff, cl_in;
   logic [PRICE_BITS-1:0] prev_ff, prev_in, bp_ff, bp_in, rng_ff, rng_in;
   logic [SUM_W-1:0]      psum_ff [3];
   logic [SUM_W-1:0]      psum_in [3];
   logic [SUM_W-1:0]      rsum_ff [3];
   logic [SUM_W-1:0]      rsum_in [3];
   logic [AW-1:0]         wpos_ff, wpos_in;
   logic [BW-1:0]         bidx_ff, bidx_in;
   logic [1:0]            sel_ff, sel_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [SUM_W-1:0]      den_ff, den_in;
   logic [Q_W-1:0]        q_ff, q_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [ultosc_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [ultosc_pkg::SCALED_W-1:0] scaled_ff, scaled_in;
   logic [ultosc_pkg::OSC_W-1:0]    osc_ff, osc_in;
   logic [ultosc_pkg::STATUS_W-1:0] stat_ff, stat_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ultosc_pkg::OSC_W-1:0]    rsp_osc_ff, rsp_osc_in;
   logic [ultosc_pkg::STATUS_W-1:0] rsp_stat_ff, rsp_stat_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_raddr;
   logic [2*PRICE_BITS-1:0] ram_rdata;

   logic                  accept, bad_win, clr_series;
   logic [PRICE_BITS-1:0] tlow, thigh, bp_raw;
   logic [REM_W-1:0]      div_a;
   logic [REM_W:0]        div_diff;
   logic [ultosc_pkg::PROD_W-1:0] prod;
   logic [SUM_W-1:0]      psum_new [3];
   logic [SUM_W-1:0]      rsum_new [3];
   logic [Q_W-1:0]        q_next;

   function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] pos,
                                               input logic [WIN_W-1:0] k);
      logic [IW-1:0] t;
      t = IW'(pos) + IW'(MAX_WINDOW) - IW'(k);
      if (t >= IW'(MAX_WINDOW)) begin
         t = t - IW'(MAX_WINDOW);
      end
      return t[AW-1:0];
   endfunction

   ultosc_ram #(.WIDTH(2 * PRICE_BITS), .DEPTH(MAX_WINDOW)) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wpos_ff),
      .wr_data ({bp_ff, rng_ff}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall      = (state_ff != ultosc_pkg::S_IDLE);
   assign accept         = req_valid && !req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_oscillator = rsp_osc_ff;
   assign rsp_status     = rsp_stat_ff;

   assign bad_win = (win_ff[0] == '0) || (win_ff[1] < win_ff[0]) ||
                    (win_ff[2] < win_ff[1]) || (IW'(win_ff[2]) > IW'(MAX_WINDOW));

   assign tlow   = (lo_ff < prev_ff) ? lo_ff : prev_ff;
   assign thigh  = (hi_ff > prev_ff) ? hi_ff : prev_ff;
   assign bp_raw = (cl_ff > tlow) ? (cl_ff - tlow) : '0;

   assign div_a    = (state_ff == ultosc_pkg::S_DIV_PRE) ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
   assign div_diff = {1'b0, div_a} - {2'b00, den_ff};
   assign q_next   = {q_ff[Q_W-2:0], ~div_diff[REM_W]};
   assign prod     = ultosc_pkg::PROD_W'(scaled_ff) *
                     ultosc_pkg::PROD_W'(ultosc_pkg::RECIP_MUL);
   assign ram_raddr = ring_back(wpos_ff, win_ff[sel_ff]);

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         psum_new[j] = psum_ff[j] + SUM_W'(bp_ff);
         rsum_new[j] = rsum_ff[j] + SUM_W'(rng_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ultosc_pkg::S_IDLE;
         win_ff[0]    <= ultosc_pkg::SHORT_RST;
         win_ff[1]    <= ultosc_pkg::MEDIUM_RST;
         win_ff[2]    <= ultosc_pkg::LONG_RST;
         prev_ff      <= '0;
         psum_ff      <= '{default: '0};
         rsum_ff      <= '{default: '0};
         wpos_ff      <= '0;
         bidx_ff      <= '0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         prev_ff      <= prev_in;
         psum_ff      <= psum_in;
         rsum_ff      <= rsum_in;
         wpos_ff      <= wpos_in;
         bidx_ff      <= bidx_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      cl_ff       <= cl_in;
      bp_ff       <= bp_in;
      rng_ff      <= rng_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      total_ff    <= total_in;
      scaled_ff   <= scaled_in;
      osc_ff      <= osc_in;
      stat_ff     <= stat_in;
      rsp_osc_ff  <= rsp_osc_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      cl_in        = cl_ff;
      prev_in      = prev_ff;
      bp_in        = bp_ff;
      rng_in       = rng_ff;
      psum_in      = psum_ff;
      rsum_in      = rsum_ff;
      wpos_in      = wpos_ff;
      bidx_in      = bidx_ff;
      sel_in       = sel_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      scaled_in    = scaled_ff;
      osc_in       = osc_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_osc_in   = rsp_osc_ff;
      rsp_stat_in  = rsp_stat_ff;
      ram_we       = 1'b0;
      clr_series   = 1'b0;

      if (csr_we) begin
         case (csr_index)
            ultosc_pkg::CSR_SHORT: begin
               win_in[0]  = csr_wdata;
               clr_series = 1'b1;
            end
            ultosc_pkg::CSR_MEDIUM: begin
               win_in[1]  = csr_wdata;
               clr_series = 1'b1;
            end
            ultosc_pkg::CSR_LONG: begin
               win_in[2]  = csr_wdata;
               clr_series = 1'b1;
            end
            default: ;
         endcase
      end

      case (state_ff)
         ultosc_pkg::S_IDLE: begin
            if (accept) begin
               hi_in = req_high_price;
               lo_in = req_low_price;
               cl_in = req_close_price;
               if (bad_win) begin
                  stat_in  = ultosc_pkg::ST_BAD;
                  osc_in   = '0;
                  state_in = ultosc_pkg::S_OUT;
               end else begin
                  if (req_restart) begin
                     clr_series = 1'b1;
                  end
                  if (req_restart || bidx_ff == '0) begin
                     prev_in    = req_close_price;
                     clr_series = 1'b1;
                  end else begin
                     state_in = ultosc_pkg::S_PREP;
                  end
               end
            end
         end
         ultosc_pkg::S_PREP: begin
            rng_in   = thigh - tlow;
            bp_in    = (bp_raw > (thigh - tlow)) ? (thigh - tlow) : bp_raw;
            prev_in  = cl_ff;
            sel_in   = '0;
            state_in = ultosc_pkg::S_RD;
         end
         ultosc_pkg::S_RD: begin
            state_in = ultosc_pkg::S_SUB;
         end
         ultosc_pkg::S_SUB: begin
            if (IW'(bidx_ff) > IW'(win_ff[sel_ff])) begin
               psum_in[sel_ff] = psum_ff[sel_ff] - SUM_W'(ram_rdata[2*PRICE_BITS-1:PRICE_BITS]);
               rsum_in[sel_ff] = rsum_ff[sel_ff] - SUM_W'(ram_rdata[PRICE_BITS-1:0]);
            end
            if (sel_ff == 2'd2) begin
               sel_in   = '0;
               state_in = ultosc_pkg::S_ADD;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = ultosc_pkg::S_RD;
            end
         end
         ultosc_pkg::S_ADD: begin
            psum_in = psum_new;
            rsum_in = rsum_new;
            ram_we  = 1'b1;
            wpos_in = (wpos_ff == AW'(MAX_WINDOW - 1)) ? '0 : wpos_ff + AW'(1);
            if (bidx_ff < BW'(MAX_WINDOW + 1)) begin
               bidx_in = bidx_ff + BW'(1);
            end
            if (IW'(bidx_ff) < IW'(win_ff[2])) begin
               state_in = ultosc_pkg::S_IDLE;
            end else if (rsum_new[0] == '0 || rsum_new[1] == '0 || rsum_new[2] == '0) begin
               stat_in  = ultosc_pkg::ST_ZERO;
               osc_in   = '0;
               state_in = ultosc_pkg::S_OUT;
            end else begin
               stat_in  = ultosc_pkg::ST_OK;
               total_in = '0;
               sel_in   = '0;
               state_in = ultosc_pkg::S_DIV_LOAD;
            end
         end
         ultosc_pkg::S_DIV_LOAD: begin
            rem_in   = REM_W'(psum_ff[sel_ff]);
            den_in   = rsum_ff[sel_ff];
            q_in     = '0;
            cnt_in   = CNT_W'(ultosc_pkg::FRAC_BITS) + CNT_W'(2'd2 - sel_ff);
            state_in = ultosc_pkg::S_DIV_PRE;
         end
         ultosc_pkg::S_DIV_PRE: begin
            if (!div_diff[REM_W]) begin
               rem_in = div_diff[REM_W-1:0];
            end
            q_in     = q_next;
            state_in = ultosc_pkg::S_DIV_STEP;
         end
         ultosc_pkg::S_DIV_STEP: begin
            rem_in = div_diff[REM_W] ? div_a : div_diff[REM_W-1:0];
            q_in   = q_next;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               total_in = total_ff + ultosc_pkg::TOTAL_W'(q_next);
               if (sel_ff == 2'd2) begin
                  state_in = ultosc_pkg::S_MUL;
               end else begin
                  sel_in   = sel_ff + 2'd1;
                  state_in = ultosc_pkg::S_DIV_LOAD;
               end
            end
         end
         ultosc_pkg::S_MUL: begin
            scaled_in = ultosc_pkg::SCALED_W'(total_ff) *
                        ultosc_pkg::SCALED_W'(ultosc_pkg::SCALE);
            state_in  = ultosc_pkg::S_RECIP;
         end
         ultosc_pkg::S_RECIP: begin
            osc_in   = prod[ultosc_pkg::RECIP_SHIFT +: ultosc_pkg::OSC_W];
            state_in = ultosc_pkg::S_OUT;
         end
         ultosc_pkg::S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_osc_in   = osc_ff;
               rsp_stat_in  = stat_ff;
               state_in     = ultosc_pkg::S_IDLE;
            end
         end
         default: state_in = ultosc_pkg::S_IDLE;
      endcase

      if (clr_series) begin
         psum_in = '{default: '0};
         rsum_in = '{default: '0};
         wpos_in = '0;
         bidx_in = '0;
         if (accept && !bad_win) begin
            bidx_in = BW'(1);
         end
      end
   end
endmodule
`default_nettype wire

[hw/rtl/ultosc_checker.sv]
// ----------------------------------------------------------------------------
// Ultimate oscillator checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ultimate_oscillator_assert.svh"
module ultosc_sva (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [ultosc_pkg::OSC_W-1:0]       rsp_oscillator,
   input wire logic [ultosc_pkg::STATUS_W-1:0]    rsp_status
);
   localparam logic [ultosc_pkg::STATUS_W-1:0] ST_OK   = ultosc_pkg::ST_OK;
   localparam logic [ultosc_pkg::STATUS_W-1:0] ST_NONE = ultosc_pkg::ST_NONE;
   localparam logic [ultosc_pkg::OSC_W-1:0]    OSC_MAX = ultosc_pkg::OSC_MAX;

   `UO_ASSERT_NOW(a_status_code, rsp_valid, rsp_status != ST_NONE)
   `UO_ASSERT_NOW(a_fault_zero, rsp_valid && rsp_status != ST_OK, rsp_oscillator == '0)
   `UO_ASSERT_NOW(a_osc_range, rsp_valid && rsp_status == ST_OK, rsp_oscillator <= OSC_MAX)
   `UO_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_oscillator) && $stable(rsp_status))
endmodule

bind ultimate_oscillator ultosc_sva u_sva (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_oscillator (rsp_oscillator),
   .rsp_status     (rsp_status)
);
`default_nettype wire
